/* hw/rtl/gbs_pkg.sv */
// ----------------------------------------------------------------------------
// gbs_pkg : shared types for the greedy box suppression block
// Word formats of the box and result channels and the layout of a kept entry.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int THR_W          = 9;
    localparam int COORD_W        = 16;
    localparam int SIZE_W         = 15;
    localparam int AREA_W         = 2 * SIZE_W;
    localparam int IDX_OUT_W      = 8;
    localparam logic [THR_W-1:0] THR_RESET = 9'd179;   // 0.7 in Q1.8

    typedef struct packed {
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic        [SIZE_W-1:0]  box_width;
        logic        [SIZE_W-1:0]  box_height;
        logic                      last_box;
    } t_box_in;

    typedef struct packed {
        logic                  keep;
        logic [IDX_OUT_W-1:0]  kept_index;
        logic                  overflow;
        logic                  frame_end;
    } t_box_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] kept_left;
        logic signed [COORD_W-1:0] kept_top;
        logic        [SIZE_W-1:0]  kept_width;
        logic        [SIZE_W-1:0]  kept_height;
        logic        [AREA_W-1:0]  kept_area;
    } t_kept_entry;

endpackage

/* hw/rtl/gbs_kept_mem.sv */
// ----------------------------------------------------------------------------
// gbs_kept_mem : kept box list storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gbs_kept_mem #(
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  gbs_pkg::t_kept_entry i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_raddr,
    output gbs_pkg::t_kept_entry o_rdata
);
    import gbs_pkg::*;

    t_kept_entry r_mem [DEPTH];
    t_kept_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/gbs_iou_cmp.sv */
// ----------------------------------------------------------------------------
// gbs_iou_cmp : pipelined overlap test
// Six stages: edges, overlaps, intersection, union, scaled terms, compare.
// Flags a hit when intersection*256 > threshold*union.
// ----------------------------------------------------------------------------
module gbs_iou_cmp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  gbs_pkg::t_kept_entry          i_cand,
    input  gbs_pkg::t_kept_entry          i_entry,
    input  logic [gbs_pkg::THR_W-1:0]     i_thr,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_busy
);
    import gbs_pkg::*;

    localparam int EDGE_W = COORD_W + 1;
    localparam int DIFF_W = COORD_W + 2;
    localparam int UNI_W  = AREA_W + 1;
    localparam int SH_W   = AREA_W + 8;
    localparam int PROD_W = THR_W + UNI_W;

    logic [5:0] r_vld;

    // stage 1
    logic signed [COORD_W-1:0] r_lo_x, r_lo_y;
    logic signed [EDGE_W-1:0]  r_hi_x, r_hi_y;
    logic [AREA_W-1:0]         r_area_b1;
    // stage 2
    logic [SIZE_W-1:0]         r_ox, r_oy;
    logic [AREA_W-1:0]         r_area_b2;
    // stage 3
    logic [AREA_W-1:0]         r_inter3;
    logic [UNI_W-1:0]          r_sum3;
    // stage 4
    logic [AREA_W-1:0]         r_inter4;
    logic [UNI_W-1:0]          r_uni4;
    // stage 5
    logic [SH_W-1:0]           r_inter_sh;
    logic [PROD_W-1:0]         r_prod;
    // stage 6
    logic                      r_hit;

    logic signed [EDGE_W-1:0]  ea_x, eb_x, ea_y, eb_y;
    logic signed [DIFF_W-1:0]  dx, dy;

    always_comb begin
        ea_x = $signed({i_cand.kept_left[COORD_W-1], i_cand.kept_left})
             + $signed({2'b00, i_cand.kept_width});
        eb_x = $signed({i_entry.kept_left[COORD_W-1], i_entry.kept_left})
             + $signed({2'b00, i_entry.kept_width});
        ea_y = $signed({i_cand.kept_top[COORD_W-1], i_cand.kept_top})
             + $signed({2'b00, i_cand.kept_height});
        eb_y = $signed({i_entry.kept_top[COORD_W-1], i_entry.kept_top})
             + $signed({2'b00, i_entry.kept_height});
        dx   = $signed({r_hi_x[EDGE_W-1], r_hi_x})
             - $signed({{2{r_lo_x[COORD_W-1]}}, r_lo_x});
        dy   = $signed({r_hi_y[EDGE_W-1], r_hi_y})
             - $signed({{2{r_lo_y[COORD_W-1]}}, r_lo_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // edges of the common region
        r_lo_x    <= (i_cand.kept_left > i_entry.kept_left) ? i_cand.kept_left
                                                            : i_entry.kept_left;
        r_lo_y    <= (i_cand.kept_top > i_entry.kept_top) ? i_cand.kept_top
                                                          : i_entry.kept_top;
        r_hi_x    <= (ea_x < eb_x) ? ea_x : eb_x;
        r_hi_y    <= (ea_y < eb_y) ? ea_y : eb_y;
        r_area_b1 <= i_entry.kept_area;
        // overlap never exceeds the smaller side, so it fits SIZE_W
        r_ox      <= (dx > 0) ? dx[SIZE_W-1:0] : '0;
        r_oy      <= (dy > 0) ? dy[SIZE_W-1:0] : '0;
        r_area_b2 <= r_area_b1;
        r_inter3  <= AREA_W'(r_ox * r_oy);
        r_sum3    <= UNI_W'(i_cand.kept_area) + UNI_W'(r_area_b2);
        // intersection is at most the smaller area, no underflow
        r_inter4  <= r_inter3;
        r_uni4    <= r_sum3 - UNI_W'(r_inter3);
        r_inter_sh <= {r_inter4, 8'h00};
        r_prod     <= PROD_W'(i_thr) * PROD_W'(r_uni4);
        // zero union implies zero intersection, which never exceeds zero
        r_hit      <= PROD_W'(r_inter_sh) > r_prod;
    end

    assign o_valid = r_vld[5];
    assign o_hit   = r_hit;
    assign o_busy  = |r_vld;

endmodule

/* hw/rtl/greedy_box_suppression.sv */
// ----------------------------------------------------------------------------
// greedy_box_suppression : greedy non-maximum suppression by overlap ratio
// Judges score-sorted boxes against the list of boxes kept in this frame.
// ----------------------------------------------------------------------------
// Usage:
//   Box channel (i_in_valid / o_in_stall / i_in_data) takes one box word at a
//   time, sorted by falling score. Result channel (o_out_valid / i_out_stall /
//   o_out_data) returns one word per box, in order.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the Q1.8
//   overlap threshold; always ready, write it only while the block is idle.
//   Each box is checked against all n kept boxes (n = kept count, up to
//   MAX_KEPT), one list read per cycle, then a six-stage compare pipeline
//   drains. A box passes through the area, scan (skipped if n = 0), drain and
//   finish states; the next box is taken only once it is finished.
//   A survivor is written to the list at index n; if the list is full it is
//   flagged overflow and not stored. The frame's last box empties the list.
//   The result sits in an output register: the next box is accepted while it
//   waits; a finished box waits for that register if the receiver stalls.
//   Reset empties the list (count only, no clearing pass) and loads the
//   threshold with 179 (0.7).
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
    parameter int MAX_KEPT = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  gbs_pkg::t_box_in           i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output gbs_pkg::t_box_out          o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gbs_pkg::THR_W-1:0]  i_cfg_data
);
    import gbs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_KEPT);
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int IDX_W  = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AREA,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state             r_state;
    t_box_in            r_item;
    t_kept_entry        r_cand;
    logic [CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]  r_rd_idx;
    logic               r_rd_vld;
    logic               r_hit;
    logic [THR_W-1:0]   r_thr;
    logic               r_out_valid;
    t_box_out           r_out;

    logic               in_fire;
    logic               out_free;
    logic               finish_go;
    logic               list_full;
    logic               mem_we;
    logic               mem_re;
    logic [CNT_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   idx_ext;
    t_kept_entry        mem_rdata;
    logic               cmp_valid;
    logic               cmp_hit;
    logic               cmp_busy;

    assign in_fire   = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign finish_go = (r_state == S_FINISH) && out_free;
    assign list_full = (r_count == CNT_W'(MAX_KEPT));
    assign mem_we    = finish_go && !r_hit && !list_full;
    assign mem_re    = (r_state == S_SCAN);
    assign cnt_m1    = r_count - 1'b1;
    assign idx_ext   = IDX_W'(r_count);

    // Kept list: written only in FINISH, read only in SCAN of a later box,
    // so a read never meets a write to the same entry in flight.
    gbs_kept_mem #(
        .DEPTH (MAX_KEPT)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_cand),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx),
        .o_rdata (mem_rdata)
    );

    gbs_iou_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_vld),
        .i_cand  (r_cand),
        .i_entry (mem_rdata),
        .i_thr   (r_thr),
        .o_valid (cmp_valid),
        .o_hit   (cmp_hit),
        .o_busy  (cmp_busy)
    );

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // box payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_data;
        end
        if (r_state == S_AREA) begin
            r_cand.kept_left   <= r_item.box_left;
            r_cand.kept_top    <= r_item.box_top;
            r_cand.kept_width  <= r_item.box_width;
            r_cand.kept_height <= r_item.box_height;
            r_cand.kept_area   <= AREA_W'(r_item.box_width * r_item.box_height);
        end
        if (finish_go) begin
            r_out.keep       <= !r_hit;
            r_out.kept_index <= (!r_hit && !list_full) ? idx_ext[IDX_OUT_W-1:0] : '0;
            r_out.overflow   <= !r_hit && list_full;
            r_out.frame_end  <= r_item.last_box;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= mem_re;
            if (cmp_valid && cmp_hit) begin
                r_hit <= 1'b1;
            end

            if (finish_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_AREA;
                    end
                end
                S_AREA: begin
                    r_hit    <= 1'b0;
                    r_rd_idx <= '0;
                    r_state  <= (r_count == '0) ? S_DRAIN : S_SCAN;
                end
                S_SCAN: begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                    if (r_rd_idx == cnt_m1[ADDR_W-1:0]) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_vld && !cmp_busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (finish_go) begin
                        if (r_item.last_box) begin
                            r_count <= '0;
                        end else if (mem_we) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // compare results must all land before the box is judged
    a_no_late_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("compare result outside scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEPT))
        else $error("kept count above list depth");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish_go && r_out_valid && !i_out_stall) |=> o_out_valid)
        else $error("result lost while loading output register");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FINISH) |=> $stable(r_count))
        else $error("kept count changed outside finish");

endmodule

/* tb/greedy_box_suppression_test.sv */
// ----------------------------------------------------------------------------
// greedy_box_suppression_test : self-checking bench for greedy box suppression
// Drives score-sorted box words, predicts keep / index / overflow per box from
// an in-bench model of the kept list, and checks every result word in order.
// A directed table comes first, then a full-list frame, then random frames.
// ----------------------------------------------------------------------------
module greedy_box_suppression_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gbs_pkg::*;

    localparam int KEPT_DEPTH     = 256;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SQUEEZE_CYCLES = 400;      // long receiver hold-off
    localparam int MAX_REPORTS    = 10;
    localparam int CHUNK_BOXES    = 30;       // random boxes per threshold setting

    typedef enum logic {ROW_BOX, ROW_CFG} t_row_kind;

    // One line of the directed plan: either a threshold write or a box word.
    // Where the outcome is obvious, the expected word is typed into the row.
    typedef struct {
        t_row_kind          kind;
        logic [THR_W-1:0]   thr;
        t_box_in            box;
        bit                 typed;
        t_box_out           want;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic               i_clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    t_box_in            in_data;
    logic               out_valid;
    logic               out_stall;
    t_box_out           out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [THR_W-1:0]   cfg_data;

    greedy_box_suppression #(
        .MAX_KEPT (KEPT_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // Predicted kept list, mirrors what the block stores for the open frame.
    int                 kept_left   [KEPT_DEPTH];
    int                 kept_top    [KEPT_DEPTH];
    int                 kept_width  [KEPT_DEPTH];
    int                 kept_height [KEPT_DEPTH];
    longint             kept_area   [KEPT_DEPTH];
    int                 kept_total  = 0;
    logic [THR_W-1:0]   iou_limit   = THR_RESET;

    t_box_out           pending_results [$];  // expected words, oldest first
    t_stim_row          stim_plan [$];
    t_box_in            frame_boxes [$];      // boxes sent in the open frame

    bit                 no_idle     = 1'b0;   // both sides run flat out
    bit                 squeeze_req = 1'b0;
    int                 cycle_count = 0;
    int                 fault_count = 0;
    int                 boxes_sent  = 0;
    int                 words_seen  = 0;
    int                 n_kept      = 0;
    int                 n_dropped   = 0;
    int                 n_overflow  = 0;
    int                 cfg_writes  = 0;
    int                 squeezes    = 0;

    // ------------------------------------------------------------------------
    // Clock and cycle guard
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycle_count, pending_results.size());
            $display("greedy_box_suppression_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // 1-D overlap of [a0, a0+alen) and [b0, b0+blen); touching spans give 0.
    function automatic longint span_overlap(input int a0, input int alen,
                                            input int b0, input int blen);
        int lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
        return (hi > lo) ? longint'(hi - lo) : 64'sd0;
    endfunction

    // Judge one box against the kept list and update the list. A pair with
    // zero union never suppresses; inter*256 > thr*union drops the box.
    function automatic t_box_out judge_box(input t_box_in b);
        t_box_out r;
        int       al, at, aw, ah, j, n;
        longint   area_a, inter, uni;
        bit       hit;
        al     = int'($signed(b.box_left));
        at     = int'($signed(b.box_top));
        aw     = int'(b.box_width);
        ah     = int'(b.box_height);
        area_a = longint'(aw) * ah;
        n      = kept_total;
        hit    = 1'b0;
        for (j = 0; j < n && !hit; j++) begin
            inter = span_overlap(al, aw, kept_left[j], kept_width[j]) *
                    span_overlap(at, ah, kept_top[j], kept_height[j]);
            uni   = area_a + kept_area[j] - inter;
            if (uni != 0 && (inter * 256) > longint'(iou_limit) * uni)
                hit = 1'b1;
        end
        r           = '0;
        r.frame_end = b.last_box;
        if (!hit) begin
            r.keep = 1'b1;
            if (n < KEPT_DEPTH) begin
                kept_left[n]   = al;
                kept_top[n]    = at;
                kept_width[n]  = aw;
                kept_height[n] = ah;
                kept_area[n]   = area_a;
                r.kept_index   = n[IDX_OUT_W-1:0];
                kept_total     = n + 1;
            end else begin
                // list full: survivor reported but never compared against
                r.overflow = 1'b1;
            end
        end
        if (b.last_box)
            kept_total = 0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function automatic int clamp_size(input int v);
        if (v < 0)
            return 0;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function automatic t_box_in pack_box(input int l, input int t, input int w,
                                         input int h, input bit last);
        t_box_in b;
        b.box_left   = l[COORD_W-1:0];
        b.box_top    = t[COORD_W-1:0];
        b.box_width  = w[SIZE_W-1:0];
        b.box_height = h[SIZE_W-1:0];
        b.last_box   = last;
        return b;
    endfunction

    // Random box: mostly a jittered copy of a box already in this frame, so
    // overlaps land near the threshold; some fresh boxes in a small field,
    // a few with zero size, and a few fully random words.
    function automatic t_box_in make_box(input bit last);
        t_box_in b;
        t_box_in base;
        int      pick, l, t, w, h;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            b.box_left   = COORD_W'($urandom);
            b.box_top    = COORD_W'($urandom);
            b.box_width  = SIZE_W'($urandom);
            b.box_height = SIZE_W'($urandom);
            b.last_box   = last;
            return b;
        end
        if (pick < 35 || frame_boxes.size() == 0) begin
            l = $urandom_range(0, 4000);
            t = $urandom_range(0, 4000);
            l = l - 2000;
            t = t - 2000;
            w = $urandom_range(0, 600);
            h = $urandom_range(0, 600);
            if ($urandom_range(0, 19) == 0)
                w = 0;
            if ($urandom_range(0, 19) == 0)
                h = 0;
        end else begin
            base = frame_boxes[$urandom_range(0, frame_boxes.size() - 1)];
            l = $urandom_range(0, 80);
            t = $urandom_range(0, 80);
            w = $urandom_range(0, 60);
            h = $urandom_range(0, 60);
            l = int'($signed(base.box_left)) + l - 40;
            t = int'($signed(base.box_top)) + t - 40;
            w = int'(base.box_width) + w - 30;
            h = int'(base.box_height) + h - 30;
        end
        return pack_box(clamp_coord(l), clamp_coord(t), clamp_size(w),
                        clamp_size(h), last);
    endfunction

    task automatic plan_box(input int l, input int t, input int w, input int h,
                            input bit last, input bit typed, input bit keep,
                            input int idx, input bit ovf);
        t_stim_row row;
        row.kind            = ROW_BOX;
        row.thr             = '0;
        row.box             = pack_box(l, t, w, h, last);
        row.typed           = typed;
        row.want.keep       = keep;
        row.want.kept_index = idx[IDX_OUT_W-1:0];
        row.want.overflow   = ovf;
        row.want.frame_end  = last;
        stim_plan = {stim_plan, row};
    endtask

    task automatic plan_cfg(input logic [THR_W-1:0] v);
        t_stim_row row;
        row.kind  = ROW_CFG;
        row.thr   = v;
        row.box   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        stim_plan = {stim_plan, row};
    endtask

    // Offer one box word and hold it until accepted. Valid is only ever
    // assigned once per falling edge.
    task automatic send_box(input t_box_in b, input bit typed, input t_box_out want);
        int       gap;
        t_box_out r;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_data  <= b;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        r = judge_box(b);
        pending_results = {pending_results, (typed ? want : r)};
        boxes_sent++;
        if (!r.keep)
            n_dropped++;
        else if (r.overflow)
            n_overflow++;
        else
            n_kept++;
    endtask

    // Threshold write, only with the block drained.
    task automatic write_threshold(input logic [THR_W-1:0] v);
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        iou_limit = v;
        cfg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, plus one long hold-off on request so the
    // block backs up and stalls the box channel.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES - 1) @(negedge i_clk);
                squeezes++;
            end else begin
                hold = pick_gap();
                out_stall <= (hold != 0);
                if (hold > 1)
                    repeat (hold - 1) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each accepted result word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_box_out want;
        if (rst_n && out_valid && !out_stall) begin
            words_seen++;
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected word: keep=%0d idx=%0d ovf=%0d end=%0d",
                             out_data.keep, out_data.kept_index,
                             out_data.overflow, out_data.frame_end);
            end else begin
                want = pending_results.pop_front();
                if (out_data.keep       !== want.keep       ||
                    out_data.kept_index !== want.kept_index ||
                    out_data.overflow   !== want.overflow   ||
                    out_data.frame_end  !== want.frame_end) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("word %0d mismatch: exp keep=%0d idx=%0d ovf=%0d end=%0d",
                                 words_seen, want.keep, want.kept_index,
                                 want.overflow, want.frame_end);
                        $display("    got keep=%0d idx=%0d ovf=%0d end=%0d",
                                 out_data.keep, out_data.kept_index,
                                 out_data.overflow, out_data.frame_end);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row        row;
        t_box_in          b;
        t_box_in          first_full;
        logic [THR_W-1:0] v;
        int               k, c, frame_left, random_sent;

        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        frame_left  = 0;
        random_sent = 0;
        rst_n       = 1'b0;
        repeat (7) @(negedge i_clk);
        rst_n = 1'b1;

        // Directed plan, reset threshold 0.7 first.
        //        left    top     w      h     last typed keep idx ovf
        plan_box(0,      0,      160,   160,   0,   1,    1,   0,  0); // first after reset
        plan_box(0,      0,      160,   160,   0,   1,    0,   0,  0); // identical: dropped
        plan_box(1000,   0,      160,   160,   0,   1,    1,   1,  0); // disjoint
        plan_box(160,    0,      160,   160,   0,   1,    1,   2,  0); // touching edge
        plan_box(0,      0,      0,     0,     0,   1,    1,   3,  0); // zero area
        plan_box(0,      0,      0,     0,     0,   1,    1,   4,  0); // zero union pair
        plan_box(-32768, -32768, 32767, 32767, 0,   1,    1,   5,  0); // low corner, max size
        plan_box(32767,  32767,  32767, 32767, 0,   1,    1,   6,  0); // high corner, max size
        plan_box(16,     16,     160,   160,   0,   0,    0,   0,  0); // IoU just under 0.7
        plan_box(5000,   5000,   16,    16,    1,   0,    0,   0,  0); // frame end
        plan_box(0,      0,      160,   160,   0,   1,    1,   0,  0); // list was emptied
        plan_box(0,      0,      160,   160,   1,   1,    0,   0,  0); // dropped last box
        plan_cfg(9'd0);                                                // any overlap drops
        plan_box(0,      0,      160,   160,   0,   1,    1,   0,  0);
        plan_box(159,    159,    16,    16,    0,   1,    0,   0,  0); // one-cell overlap
        plan_box(0,      0,      0,     0,     0,   1,    1,   1,  0); // no overlap at zero
        plan_cfg(9'd256);                                              // IoU 1 not above
        plan_box(0,      0,      160,   160,   0,   1,    1,   2,  0);
        plan_box(0,      0,      160,   160,   1,   1,    1,   3,  0);
        plan_cfg(9'd511);                                              // above 256
        plan_box(-32768, -32768, 32767, 32767, 0,   1,    1,   0,  0);
        plan_box(-32768, -32768, 32767, 32767, 1,   1,    1,   1,  0);
        plan_cfg(THR_RESET);

        foreach (stim_plan[i]) begin
            row = stim_plan[i];
            if (row.kind == ROW_CFG)
                write_threshold(row.thr);
            else
                send_box(row.box, row.typed, row.want);
        end

        // Fill the list: nothing suppresses at 256, so the frame stores all
        // KEPT_DEPTH boxes and the next survivor overflows. Run flat out.
        no_idle = 1'b1;
        write_threshold(9'd256);
        for (k = 0; k <= KEPT_DEPTH; k++) begin
            b = pack_box($urandom_range(0, 65535) - 32768,
                         $urandom_range(0, 65535) - 32768,
                         $urandom_range(1, 32767), $urandom_range(1, 32767), 1'b0);
            if (k == 0)
                first_full = b;
            send_box(b, 1'b0, '0);
        end
        // With the list full, a copy of the first box is still dropped, and
        // the closing box overflows or drops as predicted.
        write_threshold(THR_RESET);
        send_box(first_full, 1'b0, '0);
        b          = make_box(1'b1);
        send_box(b, 1'b0, '0);
        no_idle    = 1'b0;

        // Random frames over a few threshold settings.
        for (c = 0; c < 4; c++) begin
            case (c)
                0:       v = THR_RESET;
                1:       v = THR_W'($urandom_range(1, 255));
                2:       v = THR_W'($urandom_range(0, 511));
                default: v = 9'd230;
            endcase
            write_threshold(v);
            for (k = 0; k < CHUNK_BOXES; k++) begin
                if (frame_left == 0)
                    frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 10);
                b = make_box(frame_left == 1);
                frame_left--;
                if (random_sent == 30)
                    squeeze_req = 1'b1;   // receiver holds off while we keep sending
                send_box(b, 1'b0, '0);
                random_sent++;
                if (b.last_box)
                    frame_boxes.delete();
                else
                    frame_boxes = {frame_boxes, b};
            end
        end

        // Drain, then watch a while for stray words.
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (KEPT_DEPTH + 40) @(posedge i_clk);

        $display("boxes sent %0d, result words checked %0d, faults %0d",
                 boxes_sent, words_seen, fault_count);
        $display("kept %0d, dropped %0d, overflowed %0d, threshold writes %0d, long holds %0d",
                 n_kept, n_dropped, n_overflow, cfg_writes, squeezes);
        if (fault_count == 0)
            $display("greedy_box_suppression_test: done, clean");
        else
            $display("greedy_box_suppression_test: done, errors");
        $finish;
    end

endmodule

/* greedy_box_suppression.f */
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_kept_mem.sv
hw/rtl/gbs_iou_cmp.sv
hw/rtl/greedy_box_suppression.sv
tb/greedy_box_suppression_test.sv
